### hw/rtl/cdsch_pkg.sv
package cdsch_pkg;

  localparam int TRACK_W     = 16;
  localparam int TOTAL_W     = 18;
  localparam int DSIZE_W     = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISK = 1'b1;

  localparam logic [DSIZE_W-1:0] DISK_RESET = 17'd200;

  // Configuration as the sequencer sees it: head track and top track.
  typedef struct packed {
    logic [TRACK_W-1:0] head;
    logic [TRACK_W-1:0] top;
  } cfg_t;

  // One scheduled result.
  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } res_t;

endpackage

### hw/rtl/cdsch_ram.sv
module cdsch_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/cdsch_seq.sv
module cdsch_seq #(
  parameter int MaxRequests = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cdsch_pkg::TRACK_W-1:0] in_track_i,
  input  logic                          in_last_i,
  input  cdsch_pkg::cfg_t               cfg_i,
  input  logic                          out_free_i,
  output logic                          out_load_o,
  output cdsch_pkg::res_t               res_o
);
  import cdsch_pkg::*;

  localparam int AW = $clog2(MaxRequests);
  localparam int CW = $clog2(MaxRequests + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_PUT, S_START, S_UP, S_SWEEP, S_LOW
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      nl_q, nl_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [TRACK_W-1:0] val_q, val_d;
  logic               last_q, last_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TRACK_W-1:0] cur_q, cur_d;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [TRACK_W-1:0] ram_wdata, ram_rdata;

  logic [TRACK_W-1:0] t_clamp, gap_t, gap_c;
  logic               is_low, up_end, low_end;
  logic [TOTAL_W-1:0] total_step;

  // Entries are kept sorted ascending by raw track.
  cdsch_ram #(
    .Width (TRACK_W),
    .Depth (MaxRequests)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign t_clamp    = (ram_rdata > cfg_i.top) ? cfg_i.top : ram_rdata;
  assign is_low     = t_clamp < cfg_i.head;
  assign gap_t      = (cfg_i.top >= t_clamp) ? cfg_i.top - t_clamp : t_clamp - cfg_i.top;
  assign gap_c      = (cfg_i.top >= cur_q) ? cfg_i.top - cur_q : cur_q - cfg_i.top;
  assign total_step = total_q + TOTAL_W'(t_clamp - cur_q);
  assign up_end     = CW'(idx_q) == (count_q - CW'(1));
  assign low_end    = CW'(idx_q) == (nl_q - CW'(1));
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    nl_d       = nl_q;
    idx_d      = idx_q;
    val_d      = val_q;
    last_d     = last_q;
    total_d    = total_q;
    cur_d      = cur_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    out_load_o = 1'b0;
    res_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d  = in_track_i;
          last_d = in_last_i;
          if (count_q == CW'(MaxRequests)) begin
            // store full: drop the beat, but its last flag still ends the batch
            if (in_last_i) begin
              state_d = S_START;
            end
          end else if (count_q == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_track_i;
            count_d   = CW'(1);
            if (in_last_i) begin
              state_d = S_START;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(count_q - CW'(1));
            idx_d     = AW'(count_q - CW'(1));
            count_d   = count_q + CW'(1);
            state_d   = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + AW'(1);
        if (ram_rdata > val_q) begin
          // move the larger entry up one slot and keep looking down
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - AW'(1);
            idx_d     = idx_q - AW'(1);
          end
        end else begin
          ram_wdata = val_q;
          state_d   = last_q ? S_START : S_IDLE;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_q;
        state_d   = last_q ? S_START : S_IDLE;
      end
      S_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        idx_d     = '0;
        total_d   = '0;
        cur_d     = cfg_i.head;
        nl_d      = '0;
        state_d   = S_UP;
      end
      S_UP: begin
        if (is_low) begin
          // below the head: served after the wrap, just count it
          nl_d = nl_q + CW'(1);
          if (up_end) begin
            state_d = S_SWEEP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + AW'(1);
            idx_d     = idx_q + AW'(1);
          end
        end else if (out_free_i) begin
          out_load_o  = 1'b1;
          cur_d       = t_clamp;
          res_o.track = t_clamp;
          if (up_end && nl_q == '0) begin
            // no lower requests: fold sweep and jump into the final beat
            res_o.total = total_step + TOTAL_W'(gap_t) + TOTAL_W'(cfg_i.top);
            res_o.last  = 1'b1;
            count_d     = '0;
            state_d     = S_IDLE;
          end else begin
            total_d     = total_step;
            res_o.total = total_step;
            if (up_end) begin
              state_d = S_SWEEP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = idx_q + AW'(1);
              idx_d     = idx_q + AW'(1);
            end
          end
        end
      end
      S_SWEEP: begin
        total_d   = total_q + TOTAL_W'(gap_c) + TOTAL_W'(cfg_i.top);
        cur_d     = '0;
        ram_re    = 1'b1;
        ram_raddr = '0;
        idx_d     = '0;
        state_d   = S_LOW;
      end
      S_LOW: begin
        if (out_free_i) begin
          out_load_o  = 1'b1;
          cur_d       = t_clamp;
          total_d     = total_step;
          res_o.track = t_clamp;
          res_o.total = total_step;
          res_o.last  = low_end;
          if (low_end) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + AW'(1);
            idx_d     = idx_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      nl_q    <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      nl_q    <= nl_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    total_q <= total_d;
    cur_q   <= cur_d;
  end

endmodule

### hw/rtl/cscan_disk_scheduler_core.sv
// Request beat: written directly into an empty store and dropped by a full one; else inserted by
// shifting each stored entry above the new track up one slot through the one RAM write port.
// Batch end: a start state, the ascending pass over the held requests, then a sweep state and
// the pass over the requests below the head when there are any.
// Input waits until the final result is loaded; a stall on m_tready holds the schedule.
// Reset clears FSM, count, output valid, head (0), disk size (200); RAM is never read unwritten.
module cscan_disk_scheduler_core #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cdsch_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] request_track
  input  logic                                s_tlast,   // is_last_request
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cdsch_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [15:0] served_track,
                                                         // [33:16] seek_total, rest 0
  output logic                                m_tlast,   // is_last_result
  input  logic                                cfg_we_i,
  input  logic [cdsch_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cdsch_pkg::DSIZE_W-1:0]       cfg_data_i
);
  import cdsch_pkg::*;

  logic [TRACK_W-1:0] head_q;
  logic [DSIZE_W-1:0] disk_q;
  cfg_t               cfg;
  logic               out_free, out_load;
  res_t               res, out_res_q;
  logic               out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      disk_q <= DISK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEAD: head_q <= cfg_data_i[TRACK_W-1:0];
        REG_DISK: disk_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Top track: size 0 acts as 1, sizes above 65536 act as 65536.
  always_comb begin
    cfg.head = head_q;
    if (disk_q == '0) begin
      cfg.top = '0;
    end else if (disk_q[DSIZE_W-1]) begin
      cfg.top = '1;
    end else begin
      cfg.top = disk_q[TRACK_W-1:0] - TRACK_W'(1);
    end
  end

  assign out_free = !out_valid_q || m_tready;

  cdsch_seq #(
    .MaxRequests (MAX_REQUESTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .in_track_i (s_tdata[TRACK_W-1:0]),
    .in_last_i  (s_tlast),
    .cfg_i      (cfg),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= res;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {{(OUT_TDATA_W - TRACK_W - TOTAL_W){1'b0}}, out_res_q.total,
                     out_res_q.track};
  assign m_tlast  = out_res_q.last;

endmodule

### hw/rtl/cdsch_chk.sv
module cdsch_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tlast,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [cdsch_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                              m_tlast
);
  import cdsch_pkg::*;

  // Stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // Padding above seek_total stays zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:TRACK_W+TOTAL_W] == '0)
    else $error("result padding not zero");

  // Closing a batch always starts work, so input stalls the next cycle.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input ready right after batch end");

  // While a schedule is still unfinished, no new request is taken.
  a_no_input_mid_schedule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a schedule");

endmodule

bind cscan_disk_scheduler_core cdsch_chk u_cdsch_chk (.*);

### tb/tb_cscan_disk_scheduler_core.sv
`timescale 1ns / 100ps

module tb_cscan_disk_scheduler_core;
  import cdsch_pkg::*;

  localparam int MAX_REQ    = 32;
  localparam int SETTLE     = 2 * MAX_REQ + 10;
  localparam int STALL_MAX  = 4000;
  localparam int PHASE_REQS = 48;

  typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_e;

  // ROW_REQ: arg_a[15:0] is the track; ROW_CFG: arg_a is head, arg_b is disk size.
  // A row with has_want set ends a one-request batch whose single result is typed in.
  typedef struct packed {
    row_kind_e          kind;
    logic [16:0]        arg_a;
    logic [16:0]        arg_b;
    logic               last;
    logic               has_want;
    logic [TRACK_W-1:0] want_track;
    logic [TOTAL_W-1:0] want_total;
  } row_t;

  localparam int N_ROWS = 24;

  row_t dir_tab [N_ROWS] = '{
    // reset config: head 0, disk 200 -> top track 199
    '{ROW_REQ, 17'd50,    17'd0,      1'b1, 1'b1, 16'd50,    18'd398},
    '{ROW_REQ, 17'd65535, 17'd0,      1'b1, 1'b1, 16'd199,   18'd398},
    '{ROW_REQ, 17'd0,     17'd0,      1'b1, 1'b1, 16'd0,     18'd398},
    // requests on both sides of the head, one on it
    '{ROW_CFG, 17'd100,   17'd200,    1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd10,    17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd150,   17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd100,   17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd99,    17'd0,      1'b1, 1'b0, 16'd0,     18'd0},
    // zero disk size acts as one track; head far above the top
    '{ROW_CFG, 17'd65535, 17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd5,     17'd0,      1'b1, 1'b1, 16'd0,     18'd65535},
    // oversized disk acts as 65536 tracks
    '{ROW_CFG, 17'd0,     17'd131071, 1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd65535, 17'd0,      1'b1, 1'b1, 16'd65535, 18'd131070},
    '{ROW_CFG, 17'd65535, 17'd65536,  1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd0,     17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd65535, 17'd0,      1'b1, 1'b0, 16'd0,     18'd0},
    // nothing above the head: sweep lands on the first lower request
    '{ROW_CFG, 17'd40000, 17'd1000,   1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd3,     17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd999,   17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd1200,  17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd2,     17'd0,      1'b1, 1'b0, 16'd0,     18'd0},
    // nothing below the head: sweep lands on the last result
    '{ROW_CFG, 17'd300,   17'd1000,   1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd700,   17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd43690, 17'd0,      1'b0, 1'b0, 16'd0,     18'd0},
    '{ROW_REQ, 17'd300,   17'd0,      1'b1, 1'b0, 16'd0,     18'd0}
  };

  int send_idle_pct [4] = '{0, 62, 0, 19};
  int recv_stall_pct [4] = '{0, 0, 62, 19};

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [15:0] request_track
  logic                   s_tlast = 1'b0; // is_last_request
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [15:0] served_track, [33:16] seek_total
  logic                   m_tlast;        // is_last_result
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = REG_HEAD;
  logic [DSIZE_W-1:0]     cfg_data_i = '0;

  logic [TRACK_W-1:0] head_reg = '0;
  logic [DSIZE_W-1:0] disk_reg = DISK_RESET;
  logic [TRACK_W-1:0] held_q [$];
  res_t               batch_q [$];
  res_t               due_q [$];

  int send_pct = 0;
  int recv_pct = 0;
  int n_err = 0;
  int n_req = 0;
  int n_batch = 0;
  int n_res = 0;
  int n_cfg = 0;
  int quiet_cycles = 0;

  cscan_disk_scheduler_core #(
    .MAX_REQUESTS(MAX_REQ)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Hold a request; on the batch end build the C-SCAN order into batch_q.
  function automatic void take_request(logic [TRACK_W-1:0] trk, bit last);
    logic [DSIZE_W-1:0] size;
    logic [TRACK_W-1:0] top;
    logic [TRACK_W-1:0] t;
    logic [TRACK_W-1:0] cur;
    logic [TOTAL_W-1:0] total;
    logic [TRACK_W-1:0] up_q [$];
    logic [TRACK_W-1:0] lo_q [$];
    res_t r;
    batch_q.delete();
    if (held_q.size() < MAX_REQ) held_q.push_back(trk);
    if (!last) return;
    size = disk_reg;
    if (size == 0) size = 1;
    if (size > 17'd65536) size = 17'd65536;
    top = TRACK_W'(size - 1);
    foreach (held_q[i]) begin
      t = (held_q[i] > top) ? top : held_q[i];
      if (t < head_reg) lo_q.push_back(t);
      else up_q.push_back(t);
    end
    up_q.sort();
    lo_q.sort();
    cur = head_reg;
    total = '0;
    foreach (up_q[i]) begin
      total = total + (up_q[i] - cur);
      cur = up_q[i];
      r = '{track: cur, total: total, last: 1'b0};
      batch_q.push_back(r);
    end
    // sweep to the top track, then jump back to track 0
    total = total + ((top > cur) ? TOTAL_W'(top - cur) : TOTAL_W'(cur - top)) + TOTAL_W'(top);
    cur = '0;
    foreach (lo_q[i]) begin
      total = total + (lo_q[i] - cur);
      cur = lo_q[i];
      r = '{track: cur, total: total, last: 1'b0};
      batch_q.push_back(r);
    end
    r = batch_q.pop_back();
    r.total = total;
    r.last = 1'b1;
    batch_q.push_back(r);
    held_q.delete();
  endfunction

  task automatic note_err(string what, longint want, longint got);
    n_err++;
    if (n_err <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic push_beat(logic [TRACK_W-1:0] trk, bit last, bit has_want, res_t want);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= trk;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    take_request(trk, last);
    if (has_want) due_q.push_back(want);
    else foreach (batch_q[i]) due_q.push_back(batch_q[i]);
    n_req++;
    if (last) n_batch++;
  endtask

  // Drain the schedule, let the block settle, then write both registers.
  task automatic apply_config(logic [TRACK_W-1:0] head, logic [DSIZE_W-1:0] disk);
    s_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_HEAD;
    cfg_data_i <= {1'($urandom_range(1)), head};
    @(posedge clk_i);
    cfg_idx_i  <= REG_DISK;
    cfg_data_i <= disk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    head_reg = head;
    disk_reg = disk;
    n_cfg += 2;
  endtask

  task automatic random_config();
    logic [TRACK_W-1:0] head;
    logic [DSIZE_W-1:0] disk;
    case ($urandom_range(4))
      0: head = '0;
      1: head = '1;
      2: head = TRACK_W'($urandom_range(400));
      default: head = TRACK_W'($urandom);
    endcase
    case ($urandom_range(7))
      0: disk = '0;
      1: disk = 17'd1;
      2: disk = DISK_RESET;
      3: disk = 17'd65536;
      4: disk = '1;
      5: disk = DSIZE_W'($urandom_range(1, 500));
      default: disk = DSIZE_W'($urandom);
    endcase
    apply_config(head, disk);
  endtask

  // Mostly short batches with mixed tracks; now and then a long one of 28 to 40 requests, which can overflow.
  task automatic random_batch(output int count);
    logic [TRACK_W-1:0] trk;
    res_t none;
    none = '0;
    trk = '0;
    count = ($urandom_range(9) == 0) ? $urandom_range(40, 28) : $urandom_range(8, 1);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(6))
        0: trk = head_reg + TRACK_W'($urandom_range(6)) - TRACK_W'(3);
        1: trk = TRACK_W'(disk_reg) + TRACK_W'($urandom_range(4)) - TRACK_W'(2);
        2: ;  // repeat the previous track
        3: trk = TRACK_W'($urandom_range(255));
        4: trk = $urandom_range(1) ? '1 : '0;
        default: trk = TRACK_W'($urandom);
      endcase
      push_beat(trk, k == count - 1, 1'b0, none);
    end
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_pct);
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      n_res++;
      if (due_q.size() == 0) begin
        note_err("result with nothing pending, track", -1, m_tdata[15:0]);
      end else begin
        want = due_q.pop_front();
        if (m_tdata[15:0] != want.track) note_err("served_track", want.track, m_tdata[15:0]);
        if (m_tdata[33:16] != want.total) note_err("seek_total", want.total, m_tdata[33:16]);
        if (m_tlast != want.last) note_err("is_last_result", want.last, m_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               quiet_cycles, due_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int count;
    int phase_reqs;
    res_t want;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        apply_config(dir_tab[i].arg_a[TRACK_W-1:0], dir_tab[i].arg_b);
      end else begin
        want = '{track: dir_tab[i].want_track, total: dir_tab[i].want_total, last: 1'b1};
        push_beat(dir_tab[i].arg_a[TRACK_W-1:0], dir_tab[i].last, dir_tab[i].has_want, want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      random_config();
      send_pct = send_idle_pct[ph];
      recv_pct = recv_stall_pct[ph];
      phase_reqs = 0;
      while (phase_reqs < PHASE_REQS) begin
        if ($urandom_range(3) == 0) random_config();
        random_batch(count);
        phase_reqs += count;
      end
    end

    s_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (due_q.size() != 0) note_err("results left pending", 0, due_q.size());

    $display("covered %0d requests in %0d batches, %0d results checked, %0d register writes",
             n_req, n_batch, n_res, n_cfg);
    $display("phases: free flow, sender idle, receiver stall, both; overflow and clamp cases");
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cdsch_pkg.sv
hw/rtl/cdsch_ram.sv
hw/rtl/cdsch_seq.sv
hw/rtl/cscan_disk_scheduler_core.sv
hw/rtl/cdsch_chk.sv
tb/tb_cscan_disk_scheduler_core.sv
